// File: design/cau_pkg.sv
// Shared action and status codes for the complex arithmetic unit.
package cau_pkg;

   typedef enum logic [2:0] {
      ACT_ADD   = 3'd0,
      ACT_SUB   = 3'd1,
      ACT_MUL   = 3'd2,
      ACT_DIV   = 3'd3,
      ACT_CONJ  = 3'd4,
      ACT_ABS   = 3'd5,
      ACT_SQRT  = 3'd6,
      ACT_SCALE = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_DIVZ = 2'd2
   } status_type;

endpackage

// File: design/cau_req_if.sv
// Request channel: action code and two complex operands.
interface cau_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;

   modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: design/cau_rsp_if.sv
// Response channel: complex result and status.
interface cau_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] res_re;
   logic signed [31:0] res_im;
   logic [1:0]        status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// File: design/complex_arithmetic_unit_core.sv
// Complex arithmetic unit core: fully pipelined Q-format complex add/sub/mul/div/conj/abs/sqrt/scale.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+----------------------------------------
//   req     | in  | req.valid/ready   | action, a_re, a_im, b_re, b_im
//   rsp     | out | rsp.valid/ready   | res_re, res_im, status
//
// One beat enters per cycle while req.ready is high, that is while no beat is parked in the skid register.
// Depth is set by the bit-serial units: two 32-step integer square roots
// (one digit pair per stage) followed by a 33-step restoring divider (one bit per stage).
// Reset (synchronous) clears only the valid bits and the output/skid flags.
// A stall on rsp parks the finished beat in a skid register; req.ready drops the
// cycle after, freezing the whole pipe, so nothing is lost or repeated.
module complex_arithmetic_unit_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req,
   cau_rsp_if.source rsp
);

   localparam int NW         = 64 + FRAC_BITS;   // divider dividend width
   localparam int RW         = 36;               // root remainder width
   localparam int ROOT_STEPS = 32;
   localparam int QBITS      = 33;               // quotient bits kept before saturation
   localparam int R1_LAST    = ROOT_STEPS;
   localparam int W_ST       = R1_LAST + 1;
   localparam int R2_LAST    = W_ST + ROOT_STEPS;
   localparam int D_ST       = R2_LAST + 1;
   localparam int Q_LAST     = D_ST + QBITS;
   localparam int NST        = Q_LAST + 1;

   localparam logic signed [64:0] SMAX = 65'sd2147483647;
   localparam logic signed [64:0] SMIN = -65'sd2147483648;

   typedef struct packed {
      logic [2:0]        act;
      logic [31:0]       sre;
      logic [31:0]       sim;
      logic              sflag;
      logic              n1neg;
      logic              n2neg;
      logic [63:0]       m1;
      logic [63:0]       m2;
      logic [63:0]       d;
      logic              xneg;
      logic              yneg;
      logic              zero;
      logic [31:0]       ax;
      logic [31:0]       ay;
      logic [63:0]       rn;
      logic [RW-1:0]     rrem;
      logic [31:0]       rroot;
      logic [31:0]       m;
      logic [31:0]       w;
      logic [NW-1:0]     na;
      logic [NW-1:0]     nb;
      logic [63:0]       da;
      logic [63:0]       ra;
      logic [63:0]       rb;
      logic [QBITS-1:0]  qa;
      logic [QBITS-1:0]  qb;
      logic              biga;
      logic              bigb;
   } pipe_type;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic [1:0]  status;
   } res_type;

   // signed value to 32 bits: {sat flag, value}
   function automatic logic [32:0] sat_s(input logic signed [64:0] v);
      logic [32:0] r;
      if (v > SMAX)      r = {1'b1, 32'h7FFF_FFFF};
      else if (v < SMIN) r = {1'b1, 32'h8000_0000};
      else               r = {1'b0, v[31:0]};
      return r;
   endfunction

   // sign-magnitude to 32 bits: {sat flag, value}
   function automatic logic [32:0] sat_m(input logic neg, input logic [QBITS-1:0] mag,
                                         input logic big);
      logic [32:0] r;
      if (!neg) begin
         if (big || mag > 33'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else                               r = {1'b0, mag[31:0]};
      end else begin
         if (big || mag > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
         else                               r = {1'b0, 32'(33'd0 - mag)};
      end
      return r;
   endfunction

   // ---------------- flow control ----------------
   logic    en;
   logic    skid_v_ff, out_v_ff;
   res_type skid_ff, out_ff, fin;

   assign en        = !skid_v_ff;
   assign req.ready = en;

   // ---------------- S0: input capture ----------------
   logic                s0_v_ff;
   logic [2:0]          s0_act_ff;
   logic signed [31:0]  s0_ar_ff, s0_ai_ff, s0_br_ff, s0_bi_ff;

   // ---------------- S1: products ----------------
   logic                s1_v_ff;
   logic [2:0]          s1_act_ff;
   logic signed [31:0]  s1_ar_ff, s1_ai_ff;
   logic signed [63:0]  s1_pa_ff, s1_pb_ff, s1_pc_ff, s1_pd_ff, s1_pe_ff, s1_pf_ff;
   logic signed [32:0]  s1_e1_ff, s1_e2_ff;
   logic signed [32:0]  e1_in, e2_in;
   logic                sq_sel;

   // ---------------- S2: sums ----------------
   logic                s2_v_ff;
   logic [2:0]          s2_act_ff;
   logic signed [31:0]  s2_ar_ff, s2_ai_ff;
   logic signed [64:0]  s2_t1_ff, s2_t2_ff;
   logic signed [32:0]  s2_e1_ff, s2_e2_ff;
   logic [63:0]         s2_d_ff;
   logic signed [64:0]  t1_in, t2_in;

   always_comb begin
      sq_sel = (s0_act_ff == cau_pkg::ACT_ABS) || (s0_act_ff == cau_pkg::ACT_SQRT);
      e1_in  = '0;
      e2_in  = '0;
      unique case (s0_act_ff)
         cau_pkg::ACT_ADD: begin
            e1_in = {s0_ar_ff[31], s0_ar_ff} + {s0_br_ff[31], s0_br_ff};
            e2_in = {s0_ai_ff[31], s0_ai_ff} + {s0_bi_ff[31], s0_bi_ff};
         end
         cau_pkg::ACT_SUB: begin
            e1_in = {s0_ar_ff[31], s0_ar_ff} - {s0_br_ff[31], s0_br_ff};
            e2_in = {s0_ai_ff[31], s0_ai_ff} - {s0_bi_ff[31], s0_bi_ff};
         end
         cau_pkg::ACT_CONJ: begin
            e1_in = {s0_ar_ff[31], s0_ar_ff};
            e2_in = 33'sd0 - {s0_ai_ff[31], s0_ai_ff};
         end
         cau_pkg::ACT_MUL, cau_pkg::ACT_DIV, cau_pkg::ACT_ABS,
         cau_pkg::ACT_SQRT, cau_pkg::ACT_SCALE: begin
            e1_in = '0;
         end
      endcase
   end

   always_comb begin
      t1_in = '0;
      t2_in = '0;
      unique case (s1_act_ff)
         cau_pkg::ACT_MUL: begin
            t1_in = {s1_pa_ff[63], s1_pa_ff} - {s1_pb_ff[63], s1_pb_ff};
            t2_in = {s1_pc_ff[63], s1_pc_ff} + {s1_pd_ff[63], s1_pd_ff};
         end
         cau_pkg::ACT_DIV: begin
            t1_in = {s1_pa_ff[63], s1_pa_ff} + {s1_pb_ff[63], s1_pb_ff};
            t2_in = {s1_pc_ff[63], s1_pc_ff} - {s1_pd_ff[63], s1_pd_ff};
         end
         cau_pkg::ACT_ABS, cau_pkg::ACT_SQRT: begin
            // sum of squares, nonnegative
            t1_in = {s1_pa_ff[63], s1_pa_ff} + {s1_pb_ff[63], s1_pb_ff};
         end
         cau_pkg::ACT_SCALE: begin
            t1_in = {s1_pa_ff[63], s1_pa_ff};
            t2_in = {s1_pc_ff[63], s1_pc_ff};
         end
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_CONJ: begin
            t1_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_act_ff <= req.action;
         s0_ar_ff  <= req.a_re;
         s0_ai_ff  <= req.a_im;
         s0_br_ff  <= req.b_re;
         s0_bi_ff  <= req.b_im;

         s1_act_ff <= s0_act_ff;
         s1_ar_ff  <= s0_ar_ff;
         s1_ai_ff  <= s0_ai_ff;
         s1_pa_ff  <= s0_ar_ff * (sq_sel ? s0_ar_ff : s0_br_ff);
         s1_pb_ff  <= s0_ai_ff * (sq_sel ? s0_ai_ff : s0_bi_ff);
         s1_pc_ff  <= s0_ai_ff * s0_br_ff;
         s1_pd_ff  <= s0_ar_ff * s0_bi_ff;
         s1_pe_ff  <= s0_br_ff * s0_br_ff;
         s1_pf_ff  <= s0_bi_ff * s0_bi_ff;
         s1_e1_ff  <= e1_in;
         s1_e2_ff  <= e2_in;

         s2_act_ff <= s1_act_ff;
         s2_ar_ff  <= s1_ar_ff;
         s2_ai_ff  <= s1_ai_ff;
         s2_t1_ff  <= t1_in;
         s2_t2_ff  <= t2_in;
         s2_e1_ff  <= s1_e1_ff;
         s2_e2_ff  <= s1_e2_ff;
         s2_d_ff   <= s1_pe_ff[63:0] + s1_pf_ff[63:0];
      end
   end

   // ---------------- main pipe: roots, divider ----------------
   pipe_type           st_ff [NST];
   pipe_type           st_in [NST];
   pipe_type           st0_in;
   logic [NST-1:0]     vld_ff;

   // stage 0: signs, magnitudes, simple results
   always_comb begin
      pipe_type    p;
      logic [32:0] rr, ri;
      p       = '0;
      rr      = '0;
      ri      = '0;
      p.act   = s2_act_ff;
      unique case (s2_act_ff)
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_CONJ: begin
            rr = sat_s({{32{s2_e1_ff[32]}}, s2_e1_ff});
            ri = sat_s({{32{s2_e2_ff[32]}}, s2_e2_ff});
         end
         cau_pkg::ACT_MUL, cau_pkg::ACT_SCALE: begin
            // arithmetic shift of the exact product is the floor
            rr = sat_s(s2_t1_ff >>> FRAC_BITS);
            ri = sat_s(s2_t2_ff >>> FRAC_BITS);
         end
         cau_pkg::ACT_DIV, cau_pkg::ACT_ABS, cau_pkg::ACT_SQRT: begin
            rr = '0;
         end
      endcase
      p.sre   = rr[31:0];
      p.sim   = ri[31:0];
      p.sflag = rr[32] | ri[32];
      p.n1neg = s2_t1_ff[64];
      p.n2neg = s2_t2_ff[64];
      p.m1    = s2_t1_ff[64] ? 64'(-s2_t1_ff) : s2_t1_ff[63:0];
      p.m2    = s2_t2_ff[64] ? 64'(-s2_t2_ff) : s2_t2_ff[63:0];
      p.d     = s2_d_ff;
      p.xneg  = s2_ar_ff[31];
      p.yneg  = s2_ai_ff[31];
      p.zero  = (s2_ar_ff == 32'sd0) && (s2_ai_ff == 32'sd0);
      p.ax    = s2_ar_ff[31] ? 32'(-s2_ar_ff) : s2_ar_ff;
      p.ay    = s2_ai_ff[31] ? 32'(-s2_ai_ff) : s2_ai_ff;
      p.rn    = s2_t1_ff[63:0];
      st0_in  = p;
   end

   assign st_in[0] = st0_in;

   for (genvar k = 1; k < NST; k++) begin : g_stage
      if (k <= R1_LAST || (k > W_ST && k <= R2_LAST)) begin : g_root
         // one digit pair of the integer square root
         localparam int DG = (k <= R1_LAST) ? (R1_LAST - k) : (R2_LAST - k);
         pipe_type      nxt;
         logic [RW-1:0] rsh, trial;
         always_comb begin
            nxt   = st_ff[k-1];
            rsh   = {st_ff[k-1].rrem[RW-3:0], st_ff[k-1].rn[2*DG +: 2]};
            trial = {{(RW-34){1'b0}}, st_ff[k-1].rroot, 2'b01};
            if (rsh >= trial) begin
               nxt.rrem  = rsh - trial;
               nxt.rroot = {st_ff[k-1].rroot[30:0], 1'b1};
            end else begin
               nxt.rrem  = rsh;
               nxt.rroot = {st_ff[k-1].rroot[30:0], 1'b0};
            end
         end
         assign st_in[k] = nxt;
      end else if (k == W_ST) begin : g_w
         // magnitude done; radicand of the second root
         pipe_type nxt;
         always_comb begin
            nxt       = st_ff[k-1];
            nxt.m     = st_ff[k-1].rroot;
            nxt.rn    = (64'(st_ff[k-1].ax) + 64'(st_ff[k-1].rroot)) << (FRAC_BITS - 1);
            nxt.rrem  = '0;
            nxt.rroot = '0;
         end
         assign st_in[k] = nxt;
      end else if (k == D_ST) begin : g_dset
         // divider setup; quotient wider than QBITS flags saturation
         pipe_type nxt;
         always_comb begin
            nxt   = st_ff[k-1];
            nxt.w = st_ff[k-1].rroot;
            if (st_ff[k-1].act == cau_pkg::ACT_SQRT) begin
               nxt.na = NW'(st_ff[k-1].ay) << (FRAC_BITS - 1);
               nxt.da = 64'(st_ff[k-1].rroot);
            end else begin
               nxt.na = {st_ff[k-1].m1, {FRAC_BITS{1'b0}}};
               nxt.da = st_ff[k-1].d;
            end
            nxt.nb   = {st_ff[k-1].m2, {FRAC_BITS{1'b0}}};
            nxt.ra   = 64'(nxt.na >> QBITS);
            nxt.rb   = 64'(nxt.nb >> QBITS);
            nxt.biga = nxt.ra >= nxt.da;
            nxt.bigb = nxt.rb >= st_ff[k-1].d;
            nxt.qa   = '0;
            nxt.qb   = '0;
         end
         assign st_in[k] = nxt;
      end else begin : g_div
         // one quotient bit per lane
         localparam int QB = Q_LAST - k;
         pipe_type    nxt;
         logic [64:0] rsa, rsb;
         always_comb begin
            nxt = st_ff[k-1];
            rsa = {st_ff[k-1].ra, st_ff[k-1].na[QB]};
            rsb = {st_ff[k-1].rb, st_ff[k-1].nb[QB]};
            if (rsa >= {1'b0, st_ff[k-1].da}) begin
               nxt.ra = 64'(rsa - {1'b0, st_ff[k-1].da});
               nxt.qa = {st_ff[k-1].qa[QBITS-2:0], 1'b1};
            end else begin
               nxt.ra = rsa[63:0];
               nxt.qa = {st_ff[k-1].qa[QBITS-2:0], 1'b0};
            end
            if (rsb >= {1'b0, st_ff[k-1].d}) begin
               nxt.rb = 64'(rsb - {1'b0, st_ff[k-1].d});
               nxt.qb = {st_ff[k-1].qb[QBITS-2:0], 1'b1};
            end else begin
               nxt.rb = rsb[63:0];
               nxt.qb = {st_ff[k-1].qb[QBITS-2:0], 1'b0};
            end
         end
         assign st_in[k] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NST; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         vld_ff  <= '0;
      end else if (en) begin
         s0_v_ff <= req.valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         vld_ff  <= {vld_ff[NST-2:0], s2_v_ff};
      end
   end

   // ---------------- result select and saturation ----------------
   always_comb begin
      pipe_type         p;
      logic [32:0]      rr, ri;
      logic [QBITS-1:0] qv;
      logic             qbig;
      p    = st_ff[NST-1];
      rr   = '0;
      ri   = '0;
      qv   = (p.w == 32'd0) ? '0 : p.qa;
      qbig = (p.w == 32'd0) ? 1'b0 : p.biga;
      fin.status = cau_pkg::STAT_OK;
      unique case (p.act)
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_CONJ,
         cau_pkg::ACT_MUL, cau_pkg::ACT_SCALE: begin
            rr = {p.sflag, p.sre};
            ri = {1'b0, p.sim};
         end
         cau_pkg::ACT_ABS: begin
            rr = sat_m(1'b0, {1'b0, p.m}, 1'b0);
         end
         cau_pkg::ACT_DIV: begin
            if (p.d != 64'd0) begin
               rr = sat_m(p.n1neg, p.qa, p.biga);
               ri = sat_m(p.n2neg, p.qb, p.bigb);
            end
         end
         cau_pkg::ACT_SQRT: begin
            if (!p.zero) begin
               if (!p.xneg) begin
                  rr = sat_m(1'b0, {1'b0, p.w}, 1'b0);
                  ri = sat_m(p.yneg, qv, qbig);
               end else begin
                  ri = sat_m(p.yneg, {1'b0, p.w}, 1'b0);
                  rr = sat_m(1'b0, qv, qbig);
               end
            end
         end
      endcase
      fin.re = rr[31:0];
      fin.im = ri[31:0];
      if (p.act == cau_pkg::ACT_DIV && p.d == 64'd0) fin.status = cau_pkg::STAT_DIVZ;
      else if (rr[32] || ri[32])                     fin.status = cau_pkg::STAT_SAT;
   end

   // ---------------- output register and skid ----------------
   logic push, take;
   assign push = en && vld_ff[NST-1];
   assign take = out_v_ff && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end else if (push) begin
         skid_ff <= fin;
      end
   end

   assign rsp.valid  = out_v_ff;
   assign rsp.res_re = out_ff.re;
   assign rsp.res_im = out_ff.im;
   assign rsp.status = out_ff.status;

endmodule

// File: design/cau_checker.sv
// Port-level checker for the complex arithmetic unit core, with its bind.
module cau_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_res_re,
   input logic [31:0] rsp_res_im,
   input logic [1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_re) && $stable(rsp_res_im)
                                  && $stable(rsp_status))
      else $error("rsp beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == cau_pkg::STAT_OK || rsp_status == cau_pkg::STAT_SAT
                    || rsp_status == cau_pkg::STAT_DIVZ)
      else $error("reserved status code");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cau_pkg::STAT_DIVZ |-> rsp_res_re == 32'd0
                                                         && rsp_res_im == 32'd0)
      else $error("divide by zero with nonzero result");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_res_re (rsp.res_re),
   .rsp_res_im (rsp.res_im),
   .rsp_status (rsp.status)
);
